// ===== sv/ctp_pkg.sv =====
package ctp_pkg;

	// Control tag that travels with each request down the pipeline
	typedef struct packed {
		logic valid;
		logic found;
	} ctl_t;

endpackage

// ===== sv/circle_through_three_points.sv =====
// Pipeline: the depth from a request to its result strobe is set mainly by the radix-2 divider
// (COORD_WIDTH+1 stages) and the bitwise square root (COORD_WIDTH stages).
// Throughput: one request per clock; busy stays low and the receiver cannot stall.
// Reset: arst_n clears every stage valid bit and the strobe at once; data registers keep state.
module circle_through_three_points import ctp_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] first_x,
	input  logic signed [COORD_WIDTH-1:0] first_y,
	input  logic signed [COORD_WIDTH-1:0] second_x,
	input  logic signed [COORD_WIDTH-1:0] second_y,
	input  logic signed [COORD_WIDTH-1:0] third_x,
	input  logic signed [COORD_WIDTH-1:0] third_y,
	output logic                          strobe,
	output logic signed [COORD_WIDTH-1:0] center_x,
	output logic signed [COORD_WIDTH-1:0] center_y,
	output logic        [COORD_WIDTH-2:0] radius,
	output logic                          found
);

	localparam int CW  = COORD_WIDTH;
	localparam int DW  = CW + 1;          // point differences
	localparam int PW  = 2 * CW + 2;      // difference products and cross term
	localparam int XW  = 2 * CW + 3;      // doubled determinant
	localparam int LW  = 2 * CW + 1;      // squared lengths
	localparam int LOW = CW + 1;          // low slice of a squared length
	localparam int HIW = LW - LOW;        // high slice of a squared length
	localparam int PPW = DW + LOW + 1;    // partial products
	localparam int FW  = 3 * CW + 2;      // full numerator products
	localparam int NW  = 3 * CW + 3;      // numerators
	localparam int NMW = 3 * CW + 2;      // numerator magnitude
	localparam int DMW = 2 * CW + 2;      // divisor magnitude
	localparam int QB  = CW + 1;          // quotient bits
	localparam int MW  = CW + 1;          // clamped offset magnitude
	localparam int SW  = 2 * CW - 1;      // sum of squares
	localparam int RB  = CW;              // root bits
	localparam int TW  = SW + 2;          // root trial term
	localparam int LAT = 2 * CW + 13;

	assign busy = 1'b0;

	// Stage 1: differences from the first point
	ctl_t                ctl_s1;
	logic signed [DW-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [CW-1:0] x0_s1, y0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= '{valid: start, found: 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= DW'(second_x) - DW'(first_x);
		ay_s1 <= DW'(second_y) - DW'(first_y);
		bx_s1 <= DW'(third_x) - DW'(first_x);
		by_s1 <= DW'(third_y) - DW'(first_y);
		x0_s1 <= first_x;
		y0_s1 <= first_y;
	end

	// Stage 2: difference products
	ctl_t                 ctl_s2;
	logic signed [PW-1:0] axby_s2, aybx_s2, axax_s2, ayay_s2, bxbx_s2, byby_s2;
	logic signed [DW-1:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic signed [CW-1:0] x0_s2, y0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		axby_s2 <= ax_s1 * by_s1;
		aybx_s2 <= ay_s1 * bx_s1;
		axax_s2 <= ax_s1 * ax_s1;
		ayay_s2 <= ay_s1 * ay_s1;
		bxbx_s2 <= bx_s1 * bx_s1;
		byby_s2 <= by_s1 * by_s1;
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		bx_s2   <= bx_s1;
		by_s2   <= by_s1;
		x0_s2   <= x0_s1;
		y0_s2   <= y0_s1;
	end

	// Stage 3: determinant and squared lengths
	ctl_t                 ctl_s3;
	logic signed [PW-1:0] cross_s2;
	logic signed [XW-1:0] d_s3;
	logic        [LW-1:0] la_s3, lb_s3;
	logic signed [DW-1:0] ax_s3, ay_s3, bx_s3, by_s3;
	logic signed [CW-1:0] x0_s3, y0_s3;

	assign cross_s2 = axby_s2 - aybx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= '{valid: ctl_s2.valid, found: (cross_s2 != '0)};
		end
	end

	always_ff @(posedge clk) begin
		d_s3  <= $signed({cross_s2, 1'b0});
		la_s3 <= LW'($unsigned(axax_s2)) + LW'($unsigned(ayay_s2));
		lb_s3 <= LW'($unsigned(bxbx_s2)) + LW'($unsigned(byby_s2));
		ax_s3 <= ax_s2;
		ay_s3 <= ay_s2;
		bx_s3 <= bx_s2;
		by_s3 <= by_s2;
		x0_s3 <= x0_s2;
		y0_s3 <= y0_s2;
	end

	// Stage 4: numerator partial products on split lengths
	ctl_t                  ctl_s4;
	logic signed [PPW-1:0] bylo_s4, byhi_s4, aylo_s4, ayhi_s4;
	logic signed [PPW-1:0] axlo_s4, axhi_s4, bxlo_s4, bxhi_s4;
	logic signed [XW-1:0]  d_s4;
	logic signed [CW-1:0]  x0_s4, y0_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		bylo_s4 <= by_s3 * $signed({1'b0, la_s3[LOW-1:0]});
		byhi_s4 <= by_s3 * $signed({1'b0, la_s3[LW-1:LOW]});
		aylo_s4 <= ay_s3 * $signed({1'b0, lb_s3[LOW-1:0]});
		ayhi_s4 <= ay_s3 * $signed({1'b0, lb_s3[LW-1:LOW]});
		axlo_s4 <= ax_s3 * $signed({1'b0, lb_s3[LOW-1:0]});
		axhi_s4 <= ax_s3 * $signed({1'b0, lb_s3[LW-1:LOW]});
		bxlo_s4 <= bx_s3 * $signed({1'b0, la_s3[LOW-1:0]});
		bxhi_s4 <= bx_s3 * $signed({1'b0, la_s3[LW-1:LOW]});
		d_s4    <= d_s3;
		x0_s4   <= x0_s3;
		y0_s4   <= y0_s3;
	end

	// Stage 5: join partial products
	ctl_t                 ctl_s5;
	logic signed [FW-1:0] pnx_s5, qnx_s5, pny_s5, qny_s5;
	logic signed [XW-1:0] d_s5;
	logic signed [CW-1:0] x0_s5, y0_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else begin
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		pnx_s5 <= (FW'(byhi_s4) <<< LOW) + FW'(bylo_s4);
		qnx_s5 <= (FW'(ayhi_s4) <<< LOW) + FW'(aylo_s4);
		pny_s5 <= (FW'(axhi_s4) <<< LOW) + FW'(axlo_s4);
		qny_s5 <= (FW'(bxhi_s4) <<< LOW) + FW'(bxlo_s4);
		d_s5   <= d_s4;
		x0_s5  <= x0_s4;
		y0_s5  <= y0_s4;
	end

	// Stage 6: numerators
	ctl_t                 ctl_s6;
	logic signed [NW-1:0] nx_s6, ny_s6;
	logic signed [XW-1:0] d_s6;
	logic signed [CW-1:0] x0_s6, y0_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
		end else begin
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		nx_s6 <= NW'(pnx_s5) - NW'(qnx_s5);
		ny_s6 <= NW'(pny_s5) - NW'(qny_s5);
		d_s6  <= d_s5;
		x0_s6 <= x0_s5;
		y0_s6 <= y0_s5;
	end

	// Stage 7: signs and magnitudes
	ctl_t                 ctl_s7;
	logic        [NMW-1:0] nmx_s7, nmy_s7;
	logic        [DMW-1:0] dm_s7;
	logic                  negx_s7, negy_s7;
	logic signed [CW-1:0]  x0_s7, y0_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
		end else begin
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		nmx_s7  <= NMW'(nx_s6[NW-1] ? -nx_s6 : nx_s6);
		nmy_s7  <= NMW'(ny_s6[NW-1] ? -ny_s6 : ny_s6);
		dm_s7   <= DMW'(d_s6[XW-1] ? -d_s6 : d_s6);
		negx_s7 <= nx_s6[NW-1] ^ d_s6[XW-1];
		negy_s7 <= ny_s6[NW-1] ^ d_s6[XW-1];
		x0_s7   <= x0_s6;
		y0_s7   <= y0_s6;
	end

	// Divider: entry stage flags overflow and seeds the remainder, then one bit a stage
	ctl_t                 ctl_dv   [QB+1];
	logic [DMW-1:0]       remx_dv  [QB+1];
	logic [DMW-1:0]       remy_dv  [QB+1];
	logic [QB-1:0]        qx_dv    [QB+1];
	logic [QB-1:0]        qy_dv    [QB+1];
	logic [QB-1:0]        nlox_dv  [QB+1];
	logic [QB-1:0]        nloy_dv  [QB+1];
	logic [DMW-1:0]       dm_dv    [QB+1];
	logic                 negx_dv  [QB+1];
	logic                 negy_dv  [QB+1];
	logic                 ovfx_dv  [QB+1];
	logic                 ovfy_dv  [QB+1];
	logic signed [CW-1:0] x0_dv    [QB+1];
	logic signed [CW-1:0] y0_dv    [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_dv[0] <= '0;
		end else begin
			ctl_dv[0] <= ctl_s7;
		end
	end

	always_ff @(posedge clk) begin
		ovfx_dv[0] <= {1'b0, nmx_s7} >= {dm_s7, {QB{1'b0}}};
		ovfy_dv[0] <= {1'b0, nmy_s7} >= {dm_s7, {QB{1'b0}}};
		remx_dv[0] <= DMW'(nmx_s7[NMW-1:QB]);
		remy_dv[0] <= DMW'(nmy_s7[NMW-1:QB]);
		nlox_dv[0] <= nmx_s7[QB-1:0];
		nloy_dv[0] <= nmy_s7[QB-1:0];
		qx_dv[0]   <= '0;
		qy_dv[0]   <= '0;
		dm_dv[0]   <= dm_s7;
		negx_dv[0] <= negx_s7;
		negy_dv[0] <= negy_s7;
		x0_dv[0]   <= x0_s7;
		y0_dv[0]   <= y0_s7;
	end

	for (genvar j = 1; j <= QB; j++) begin : g_div
		logic [DMW:0] tx, ty;
		logic         gex, gey;

		// Bring down the next numerator bit and try the divisor
		always_comb begin
			tx  = {remx_dv[j-1], nlox_dv[j-1][QB-1]};
			ty  = {remy_dv[j-1], nloy_dv[j-1][QB-1]};
			gex = tx >= {1'b0, dm_dv[j-1]};
			gey = ty >= {1'b0, dm_dv[j-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_dv[j] <= '0;
			end else begin
				ctl_dv[j] <= ctl_dv[j-1];
			end
		end

		always_ff @(posedge clk) begin
			remx_dv[j] <= gex ? DMW'(tx - {1'b0, dm_dv[j-1]}) : DMW'(tx);
			remy_dv[j] <= gey ? DMW'(ty - {1'b0, dm_dv[j-1]}) : DMW'(ty);
			qx_dv[j]   <= {qx_dv[j-1][QB-2:0], gex};
			qy_dv[j]   <= {qy_dv[j-1][QB-2:0], gey};
			nlox_dv[j] <= {nlox_dv[j-1][QB-2:0], 1'b0};
			nloy_dv[j] <= {nloy_dv[j-1][QB-2:0], 1'b0};
			dm_dv[j]   <= dm_dv[j-1];
			negx_dv[j] <= negx_dv[j-1];
			negy_dv[j] <= negy_dv[j-1];
			ovfx_dv[j] <= ovfx_dv[j-1];
			ovfy_dv[j] <= ovfy_dv[j-1];
			x0_dv[j]   <= x0_dv[j-1];
			y0_dv[j]   <= y0_dv[j-1];
		end
	end

	// Rounding stage: round half away, clamp offsets at 2^CW
	ctl_t                 ctl_rn;
	logic [MW-1:0]        magx_rn, magy_rn;
	logic                 negx_rn, negy_rn;
	logic signed [CW-1:0] x0_rn, y0_rn;
	logic                 upx, upy, bigx, bigy;
	logic [QB:0]          qrx, qry;

	always_comb begin
		upx  = {remx_dv[QB], 1'b0} >= {1'b0, dm_dv[QB]};
		upy  = {remy_dv[QB], 1'b0} >= {1'b0, dm_dv[QB]};
		qrx  = {1'b0, qx_dv[QB]} + (QB+1)'(upx);
		qry  = {1'b0, qy_dv[QB]} + (QB+1)'(upy);
		bigx = ovfx_dv[QB] || (qrx > ((QB+1)'(1) << CW));
		bigy = ovfy_dv[QB] || (qry > ((QB+1)'(1) << CW));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_rn <= '0;
		end else begin
			ctl_rn <= ctl_dv[QB];
		end
	end

	always_ff @(posedge clk) begin
		magx_rn <= bigx ? (MW'(1) << CW) : MW'(qrx);
		magy_rn <= bigy ? (MW'(1) << CW) : MW'(qry);
		negx_rn <= negx_dv[QB];
		negy_rn <= negy_dv[QB];
		x0_rn   <= x0_dv[QB];
		y0_rn   <= y0_dv[QB];
	end

	// Square stage: center with saturation, offset squares
	ctl_t                 ctl_sq;
	logic signed [CW+2:0] cxw, cyw;
	logic signed [CW-1:0] cxs, cys;
	logic signed [CW-1:0] cx_sq, cy_sq;
	logic                 satr_sq;
	logic [2*CW-3:0]      sqx_sq, sqy_sq;

	always_comb begin
		cxw = negx_rn ? $signed((CW+3)'(x0_rn) - (CW+3)'(magx_rn))
		              : $signed((CW+3)'(x0_rn) + (CW+3)'(magx_rn));
		cyw = negy_rn ? $signed((CW+3)'(y0_rn) - (CW+3)'(magy_rn))
		              : $signed((CW+3)'(y0_rn) + (CW+3)'(magy_rn));
		if (cxw[CW+2:CW-1] == '0 || cxw[CW+2:CW-1] == '1) begin
			cxs = cxw[CW-1:0];
		end else begin
			cxs = cxw[CW+2] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end
		if (cyw[CW+2:CW-1] == '0 || cyw[CW+2:CW-1] == '1) begin
			cys = cyw[CW-1:0];
		end else begin
			cys = cyw[CW+2] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sq <= '0;
		end else begin
			ctl_sq <= ctl_rn;
		end
	end

	always_ff @(posedge clk) begin
		cx_sq   <= cxs;
		cy_sq   <= cys;
		satr_sq <= (magx_rn[CW:CW-1] != '0) || (magy_rn[CW:CW-1] != '0);
		sqx_sq  <= magx_rn[CW-2:0] * magx_rn[CW-2:0];
		sqy_sq  <= magy_rn[CW-2:0] * magy_rn[CW-2:0];
	end

	// Square root: entry stage sums the squares, then one root bit a stage
	ctl_t                 ctl_sr  [RB+1];
	logic [SW-1:0]        rem_sr  [RB+1];
	logic [RB-1:0]        root_sr [RB+1];
	logic signed [CW-1:0] cx_sr   [RB+1];
	logic signed [CW-1:0] cy_sr   [RB+1];
	logic                 satr_sr [RB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sr[0] <= '0;
		end else begin
			ctl_sr[0] <= ctl_sq;
		end
	end

	always_ff @(posedge clk) begin
		rem_sr[0]  <= SW'(sqx_sq) + SW'(sqy_sq);
		root_sr[0] <= '0;
		cx_sr[0]   <= cx_sq;
		cy_sr[0]   <= cy_sq;
		satr_sr[0] <= satr_sq;
	end

	for (genvar k = 1; k <= RB; k++) begin : g_sqrt
		localparam int I = RB - k;
		logic [TW-1:0] t;
		logic          ge;

		// Try setting root bit I against the running remainder
		always_comb begin
			t  = (TW'(root_sr[k-1]) << (I + 1)) + (TW'(1) << (2 * I));
			ge = {2'b00, rem_sr[k-1]} >= t;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sr[k] <= '0;
			end else begin
				ctl_sr[k] <= ctl_sr[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_sr[k]  <= ge ? SW'({2'b00, rem_sr[k-1]} - t) : rem_sr[k-1];
			root_sr[k] <= root_sr[k-1] | (RB'(ge) << I);
			cx_sr[k]   <= cx_sr[k-1];
			cy_sr[k]   <= cy_sr[k-1];
			satr_sr[k] <= satr_sr[k-1];
		end
	end

	// Output stage: round the root, saturate, zero a missing circle
	logic          upr, bigr;
	logic [RB:0]   rr;

	always_comb begin
		upr  = rem_sr[RB] > SW'(root_sr[RB]);
		rr   = {1'b0, root_sr[RB]} + (RB+1)'(upr);
		bigr = satr_sr[RB] || (rr[RB:CW-1] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= ctl_sr[RB].valid;
		end
	end

	always_ff @(posedge clk) begin
		found    <= ctl_sr[RB].found;
		center_x <= ctl_sr[RB].found ? cx_sr[RB] : '0;
		center_y <= ctl_sr[RB].found ? cy_sr[RB] : '0;
		if (!ctl_sr[RB].found) begin
			radius <= '0;
		end else if (bigr) begin
			radius <= '1;
		end else begin
			radius <= rr[CW-2:0];
		end
	end

	// Every request comes out after the fixed pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT strobe)
		else $error("request did not produce a result at the pipeline depth");

	// A missing circle reports all-zero geometry
	a_zero_when_missing: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !found) |-> (center_x == '0 && center_y == '0 && radius == '0))
		else $error("missing circle with nonzero outputs");

	// Divider remainder stays below the divisor for a found circle unless the quotient overflowed
	a_div_rem_x: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_dv[QB].valid && ctl_dv[QB].found && !ovfx_dv[QB]) |->
		(remx_dv[QB] < dm_dv[QB]))
		else $error("x divider remainder not below divisor");

	a_div_rem_y: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_dv[QB].valid && ctl_dv[QB].found && !ovfy_dv[QB]) |->
		(remy_dv[QB] < dm_dv[QB]))
		else $error("y divider remainder not below divisor");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int CW = 32;
	localparam int LATENCY = 2 * CW + 13;
	localparam int N_RANDOM = 1530;
	localparam logic signed [191:0] OFS_CLAMP = 192'sd1 <<< 60;
	localparam logic signed [63:0] COORD_HI = 64'sd2147483647;
	localparam logic signed [63:0] COORD_LO = -64'sd2147483648;
	localparam logic [63:0] RADIUS_HI = 64'd2147483647;

	typedef struct {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [CW-2:0] rad;
		logic fnd;
	} circle_t;

	typedef struct {
		logic signed [CW-1:0] p[6];
		logic known;
		circle_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CW-1:0] first_x = '0, first_y = '0, second_x = '0;
	logic signed [CW-1:0] second_y = '0, third_x = '0, third_y = '0;
	logic strobe;
	logic signed [CW-1:0] center_x, center_y;
	logic [CW-2:0] radius;
	logic found;

	circle_t pending_circles[$];
	int mismatches = 0;
	int n_requests = 0;
	int n_results = 0;
	int n_found = 0;
	row_t dir_rows[$];

	circle_through_three_points #(.COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_x(first_x), .first_y(first_y), .second_x(second_x),
		.second_y(second_y), .third_x(third_x), .third_y(third_y),
		.strobe(strobe), .center_x(center_x), .center_y(center_y),
		.radius(radius), .found(found)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Signed divide rounded to nearest, ties away from zero, clamped to 2^60
	function automatic logic signed [191:0] div_round(logic signed [191:0] n,
			logic signed [191:0] d);
		logic neg;
		logic [191:0] an, ad, q, r;
		neg = n[191] ^ d[191];
		an = n[191] ? -n : n;
		ad = d[191] ? -d : d;
		q = an / ad;
		r = an % ad;
		if ((r << 1) >= ad) q = q + 1;
		if (q > OFS_CLAMP) q = OFS_CLAMP;
		return neg ? -$signed(q) : $signed(q);
	endfunction

	// Predict center and radius of the circle through three points
	function automatic circle_t predict_circle(logic signed [CW-1:0] p[6]);
		logic signed [191:0] ax, ay, bx, by, d, la, lb, ux, uy, s, rr, t, cxw, cyw;
		circle_t c;
		ax = p[2] - p[0];
		ay = p[3] - p[1];
		bx = p[4] - p[0];
		by = p[5] - p[1];
		d = 2 * (ax * by - ay * bx);
		c = '{default: '0};
		if (d == 0) return c;
		la = ax * ax + ay * ay;
		lb = bx * bx + by * by;
		ux = div_round(by * la - ay * lb, d);
		uy = div_round(ax * lb - bx * la, d);
		s = ux * ux + uy * uy;
		rr = 0;
		for (int b = 60; b >= 0; b--) begin
			t = rr | (192'sd1 <<< b);
			if (t * t <= s) rr = t;
		end
		if (s - rr * rr > rr) rr = rr + 1;
		if (rr > RADIUS_HI) rr = RADIUS_HI;
		cxw = p[0] + ux;
		cyw = p[1] + uy;
		if (cxw > COORD_HI) cxw = COORD_HI;
		if (cxw < COORD_LO) cxw = COORD_LO;
		if (cyw > COORD_HI) cyw = COORD_HI;
		if (cyw < COORD_LO) cyw = COORD_LO;
		c.cx = cxw[CW-1:0];
		c.cy = cyw[CW-1:0];
		c.rad = rr[CW-2:0];
		c.fnd = 1'b1;
		return c;
	endfunction

	// Drive one request and hold it until taken
	task automatic send_request(logic signed [CW-1:0] p[6], logic known, circle_t res);
		circle_t want;
		want = known ? res : predict_circle(p);
		first_x <= p[0]; first_y <= p[1]; second_x <= p[2];
		second_y <= p[3]; third_x <= p[4]; third_y <= p[5];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_circles.push_back(want);
		n_requests++;
		@(negedge clk);
	endtask

	function automatic logic signed [CW-1:0] rand_coord(int mode);
		case (mode)
			0: return $signed($urandom());
			1: return $signed(CW'($urandom_range(0, 2000)) - CW'(1000)) <<< 16;
			2: return $signed($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
			default: return $signed(CW'($urandom_range(0, 65535)) - CW'(32768));
		endcase
	endfunction

	// Compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			circle_t want;
			n_results++;
			if (found) n_found++;
			if (pending_circles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at %0t", $time);
			end else begin
				want = pending_circles.pop_front();
				if (want.cx !== center_x || want.cy !== center_y ||
						want.rad !== radius || want.fnd !== found) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp cx=%0d cy=%0d r=%0d f=%0b got cx=%0d cy=%0d r=%0d f=%0b",
							want.cx, want.cy, want.rad, want.fnd,
							center_x, center_y, radius, found);
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	function automatic row_t mk(int a, int b, int c, int d, int e, int f, logic known);
		row_t r;
		r.p[0] = a; r.p[1] = b; r.p[2] = c; r.p[3] = d; r.p[4] = e; r.p[5] = f;
		r.known = known;
		r.res = '{default: '0};
		return r;
	endfunction

	initial begin
		logic signed [CW-1:0] pts[6];
		circle_t none;
		int idx, mode, burst, drain;
		logic drained;
		none = '{default: '0};
		drained = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: coincident, collinear, extremes, simple circles
		dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 1));
		dir_rows.push_back(mk(5, 5, 5, 5, 5, 5, 1));
		dir_rows.push_back(mk(0, 0, 65536, 65536, 131072, 131072, 1));
		dir_rows.push_back(mk(0, 0, 65536, 0, -65536, 0, 1));
		dir_rows.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			0, 0, 0));
		dir_rows.push_back(mk(65536, 0, 0, 65536, -65536, 0, 0));
		dir_rows.push_back(mk(0, 0, 131072, 0, 0, 131072, 0));
		dir_rows.push_back(mk(0, 0, 1, 0, 0, 1, 0));
		dir_rows.push_back(mk(0, 0, 1, 0, 2, 1, 0));
		dir_rows.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 0));
		dir_rows.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff, 0));
		dir_rows.push_back(mk(0, 0, 1, 0, 32'h7fffffff, 1, 0));
		dir_rows.push_back(mk(32'h7fffffff, 0, 32'h7ffffffe, 1, 32'h7ffffffd, 0, 0));
		dir_rows.push_back(mk(32'h80000000, 0, 32'h7fffffff, 0, 32'h80000000, 1, 0));
		dir_rows.push_back(mk(-65536, -65536, 65536, -65536, 65536, 65536, 0));
		dir_rows.push_back(mk(32'hffffffff, 32'haaaaaaaa, 32'h55555555, 32'h12345678,
			32'hedcba987, 32'h0f0f0f0f, 0));
		foreach (dir_rows[i]) begin
			pts = dir_rows[i].p;
			send_request(pts, dir_rows[i].known, dir_rows[i].res);
		end

		// Random bursts with gaps; mostly small well-formed triples
		idx = 0;
		while (idx < N_RANDOM) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && idx < N_RANDOM; k++) begin
				mode = $urandom_range(0, 9);
				if (mode < 3) mode = 0;
				else if (mode < 7) mode = 1;
				else if (mode < 8) mode = 2;
				else mode = 3;
				foreach (pts[j]) pts[j] = ($urandom_range(0, 7) == 0) ?
					rand_coord($urandom_range(0, 3)) : rand_coord(mode);
				// Force collinear now and then
				if ($urandom_range(0, 15) == 0) begin
					pts[4] = pts[2]; pts[5] = pts[3];
				end
				send_request(pts, 1'b0, none);
				idx++;
				if (!drained && idx == N_RANDOM / 2) break;
			end
			if (!drained && idx == N_RANDOM / 2) begin
				// Hold off until the pipeline is empty
				drained = 1'b1;
				start <= 1'b0;
				while (pending_circles.size() != 0) @(negedge clk);
			end else if (idx < N_RANDOM && $urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 90)) @(negedge clk);
			end
		end
		start <= 1'b0;

		drain = 0;
		while (pending_circles.size() != 0 && drain < 100 * LATENCY) begin
			@(negedge clk);
			drain++;
		end
		repeat (LATENCY + 5) @(negedge clk);
		mismatches += pending_circles.size();

		$display("requests sent %0d, results checked %0d, circles found %0d",
			n_requests, n_results, n_found);
		$display("covered coincident, collinear, extreme and random triples");
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
